// ===== rtl/tts_pkg.sv =====
// Package for the text terminal scrollback buffer.
// Holds geometry constants, field widths, action and command codes, and the command struct.
// No dependencies.
`default_nettype none

package tts_pkg;

    // Terminal geometry
    localparam int COLUMNS         = 64;
    localparam int SCREEN_ROWS     = 16;
    localparam int SCROLLBACK_ROWS = 48;
    localparam int TOTAL_ROWS      = SCREEN_ROWS + SCROLLBACK_ROWS;
    localparam int TOTAL_CHARS     = TOTAL_ROWS * COLUMNS;
    localparam int LAST_VIEW       = TOTAL_ROWS - SCREEN_ROWS;

    // Internal widths
    localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int ROW_W  = (TOTAL_ROWS > 1) ? $clog2(TOTAL_ROWS) : 1;
    localparam int CROW_W = $clog2(TOTAL_ROWS + 1);
    localparam int VIEW_W = (LAST_VIEW > 0) ? $clog2(LAST_VIEW + 1) : 1;
    localparam int FILL_W = $clog2(COLUMNS + 1);
    localparam int ADDR_W = (TOTAL_CHARS > 1) ? $clog2(TOTAL_CHARS) : 1;

    // Port field widths
    localparam int ACTION_W   = 2;
    localparam int CHAR_W     = 8;
    localparam int SROW_W     = 4;
    localparam int SCOL_W     = 6;
    localparam int VIEW_OUT_W = 6;
    localparam int CROW_OUT_W = 7;
    localparam int CCOL_OUT_W = 6;

    // Command queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'd0;

    typedef enum logic [ACTION_W-1:0] {
        ACT_WRITE     = 2'd0,
        ACT_PAGE_UP   = 2'd1,
        ACT_PAGE_DOWN = 2'd2,
        ACT_READ      = 2'd3
    } t_action;

    // Classified command passed from front to back
    typedef enum logic [2:0] {
        OP_CHAR      = 3'd0,  // printable byte
        OP_NEWLINE   = 3'd1,  // CR or LF starting a new row
        OP_PAIR_SKIP = 3'd2,  // second half of a CR-LF / LF-CR pair
        OP_PAGE_UP   = 3'd3,
        OP_PAGE_DOWN = 3'd4,
        OP_READ      = 3'd5,  // cell inside the screen
        OP_READ_OFF  = 3'd6   // cell outside the screen
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [CHAR_W-1:0] code;
        logic [SROW_W-1:0] row;
        logic [SCOL_W-1:0] col;
    } t_cmd;

    typedef enum logic {
        BK_EXEC = 1'b0,
        BK_READ = 1'b1
    } t_back_state;

endpackage

`default_nettype wire

// ===== rtl/tts_front.sv =====
// Front end: accepts input items and classifies them into commands.
// Tracks the previous written byte to fold CR-LF / LF-CR pairs. Uses tts_pkg.
`default_nettype none

module tts_front (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire  [tts_pkg::ACTION_W-1:0] i_action,
    input  wire  [tts_pkg::CHAR_W-1:0]   i_char_code,
    input  wire  [tts_pkg::SROW_W-1:0]   i_screen_row,
    input  wire  [tts_pkg::SCOL_W-1:0]   i_screen_column,
    output logic                         o_cmd_valid,
    output tts_pkg::t_cmd                o_cmd,
    input  wire                          i_cmd_ready
);

    logic [tts_pkg::CHAR_W-1:0] r_prev_char;
    logic [tts_pkg::CHAR_W-1:0] n_prev_char;
    logic                       accept;
    logic                       is_break;
    logic                       paired;
    logic                       in_screen;
    tts_pkg::t_action           act;

    assign o_ready     = i_cmd_ready;
    assign o_cmd_valid = i_valid;
    assign accept      = i_valid && i_cmd_ready;
    assign act         = tts_pkg::t_action'(i_action);

    // Line break detection and pair folding
    assign is_break = (i_char_code == tts_pkg::CHAR_CR) || (i_char_code == tts_pkg::CHAR_LF);
    assign paired   = ((i_char_code == tts_pkg::CHAR_CR) && (r_prev_char == tts_pkg::CHAR_LF))
                   || ((i_char_code == tts_pkg::CHAR_LF) && (r_prev_char == tts_pkg::CHAR_CR));

    assign in_screen = (32'(i_screen_row) < tts_pkg::SCREEN_ROWS)
                    && (32'(i_screen_column) < tts_pkg::COLUMNS);

    // Classify
    always_comb begin
        o_cmd.code  = i_char_code;
        o_cmd.row   = i_screen_row;
        o_cmd.col   = i_screen_column;
        n_prev_char = r_prev_char;
        unique case (act)
            tts_pkg::ACT_WRITE: begin
                if (is_break) begin
                    o_cmd.op = paired ? tts_pkg::OP_PAIR_SKIP : tts_pkg::OP_NEWLINE;
                end else begin
                    o_cmd.op = tts_pkg::OP_CHAR;
                end
                if (accept) begin
                    n_prev_char = i_char_code;
                end
            end
            tts_pkg::ACT_PAGE_UP:   o_cmd.op = tts_pkg::OP_PAGE_UP;
            tts_pkg::ACT_PAGE_DOWN: o_cmd.op = tts_pkg::OP_PAGE_DOWN;
            tts_pkg::ACT_READ: begin
                o_cmd.op = in_screen ? tts_pkg::OP_READ : tts_pkg::OP_READ_OFF;
            end
            default:                o_cmd.op = tts_pkg::OP_READ_OFF;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_char <= tts_pkg::CHAR_NONE;
        end else begin
            r_prev_char <= n_prev_char;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tts_queue.sv =====
// Short command queue between the front end and the back end.
// Circular buffer of tts_pkg::t_cmd entries with a fill count. Uses tts_pkg.
`default_nettype none

module tts_queue (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push_valid,
    output logic               o_push_ready,
    input  wire tts_pkg::t_cmd i_push_cmd,
    output logic               o_pop_valid,
    input  wire                i_pop_ready,
    output tts_pkg::t_cmd      o_pop_cmd
);

    tts_pkg::t_cmd               r_entry [tts_pkg::QUEUE_DEPTH];
    logic [tts_pkg::QPTR_W-1:0]  r_wr_ptr;
    logic [tts_pkg::QPTR_W-1:0]  r_rd_ptr;
    logic [tts_pkg::QCNT_W-1:0]  r_count;
    logic                        push;
    logic                        pop;

    assign o_push_ready = (r_count != tts_pkg::QCNT_W'(tts_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_entry[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (32'(r_wr_ptr) == tts_pkg::QUEUE_DEPTH - 1)
                          ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (32'(r_rd_ptr) == tts_pkg::QUEUE_DEPTH - 1)
                          ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_entry[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tts_back.sv =====
// Back end: executes commands against the text store and drives the result register.
// Ring base row makes a scroll a base step, not a row copy; per-row fill lengths stand in for blanking.
// Uses tts_pkg.
`default_nettype none

module tts_back (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cmd_valid,
    output logic                            o_cmd_ready,
    input  wire tts_pkg::t_cmd              i_cmd,
    output logic                            o_valid,
    input  wire                             i_ready,
    output logic [tts_pkg::CHAR_W-1:0]      o_cell_char,
    output logic                            o_cell_is_live,
    output logic [tts_pkg::VIEW_OUT_W-1:0]  o_view_top_row,
    output logic [tts_pkg::CROW_OUT_W-1:0]  o_cursor_row,
    output logic [tts_pkg::CCOL_OUT_W-1:0]  o_cursor_column
);

    // Store row to physical row through the ring base
    function automatic logic [tts_pkg::ROW_W-1:0] phys_row(
        input logic [tts_pkg::ROW_W-1:0] row,
        input logic [tts_pkg::ROW_W-1:0] base
    );
        logic [tts_pkg::ROW_W:0] sum;
        sum = {1'b0, row} + {1'b0, base};
        if (sum >= (tts_pkg::ROW_W + 1)'(tts_pkg::TOTAL_ROWS)) begin
            sum = sum - (tts_pkg::ROW_W + 1)'(tts_pkg::TOTAL_ROWS);
        end
        return sum[tts_pkg::ROW_W-1:0];
    endfunction

    function automatic logic [tts_pkg::ADDR_W-1:0] cell_addr(
        input logic [tts_pkg::ROW_W-1:0] prow,
        input logic [tts_pkg::COL_W-1:0] col
    );
        return tts_pkg::ADDR_W'(prow) * tts_pkg::ADDR_W'(tts_pkg::COLUMNS)
             + tts_pkg::ADDR_W'(col);
    endfunction

    // Architectural state
    logic [tts_pkg::CROW_W-1:0] r_cur_row, n_cur_row;
    logic [tts_pkg::COL_W-1:0]  r_cur_col, n_cur_col;
    logic [tts_pkg::ROW_W-1:0]  r_base, n_base;
    logic [tts_pkg::VIEW_W-1:0] r_view, n_view;
    logic [tts_pkg::FILL_W-1:0] r_fill [tts_pkg::TOTAL_ROWS];
    tts_pkg::t_back_state       r_state, n_state;

    // Text store
    logic [tts_pkg::CHAR_W-1:0] r_mem [tts_pkg::TOTAL_CHARS];
    logic [tts_pkg::CHAR_W-1:0] r_rd_data;
    logic                       r_rd_hit, n_rd_hit;
    logic                       r_rd_live, n_rd_live;

    // Result register
    logic                        r_out_valid, n_out_valid;
    logic [tts_pkg::CHAR_W-1:0]  r_out_char, n_out_char;
    logic                        r_out_live, n_out_live;
    logic [tts_pkg::VIEW_W-1:0]  r_out_view, n_out_view;
    logic [tts_pkg::CROW_W-1:0]  r_out_crow, n_out_crow;
    logic [tts_pkg::COL_W-1:0]   r_out_ccol, n_out_ccol;

    // Datapath helpers
    logic                        pop;
    logic                        scroll;
    logic [tts_pkg::ROW_W-1:0]   row_eff;
    logic [tts_pkg::COL_W-1:0]   col_eff;
    logic [tts_pkg::ROW_W-1:0]   wr_prow;
    logic [tts_pkg::ROW_W-1:0]   base_inc;
    logic [tts_pkg::ROW_W-1:0]   st_row;
    logic [tts_pkg::ROW_W-1:0]   rd_prow;
    logic [tts_pkg::COL_W-1:0]   rd_col;
    logic                        mem_we;
    logic                        mem_re;
    logic [tts_pkg::ADDR_W-1:0]  mem_waddr;
    logic [tts_pkg::ADDR_W-1:0]  mem_raddr;
    logic                        fill_clr;
    logic                        fill_set;
    logic [tts_pkg::FILL_W-1:0]  fill_val;
    int                          view_sum;

    assign o_cmd_ready = (r_state == tts_pkg::BK_EXEC) && (!r_out_valid || i_ready);
    assign pop         = i_cmd_valid && o_cmd_ready;

    // A pending scroll shows as the cursor one row past the store
    assign scroll   = (r_cur_row == tts_pkg::CROW_W'(tts_pkg::TOTAL_ROWS));
    assign row_eff  = scroll ? tts_pkg::ROW_W'(tts_pkg::TOTAL_ROWS - 1)
                             : r_cur_row[tts_pkg::ROW_W-1:0];
    assign col_eff  = scroll ? '0 : r_cur_col;
    assign base_inc = (32'(r_base) == tts_pkg::TOTAL_ROWS - 1) ? '0 : r_base + 1'b1;
    // after a scroll the last row lands on the old base
    assign wr_prow  = scroll ? r_base : phys_row(row_eff, r_base);

    // Read address path
    assign st_row    = tts_pkg::ROW_W'(32'(r_view) + 32'(i_cmd.row));
    assign rd_prow   = phys_row(st_row, r_base);
    assign rd_col    = tts_pkg::COL_W'(i_cmd.col);
    assign mem_raddr = cell_addr(rd_prow, rd_col);
    assign mem_waddr = cell_addr(wr_prow, col_eff);
    assign fill_val  = tts_pkg::FILL_W'(col_eff) + 1'b1;

    // Command execution and next state
    always_comb begin
        n_state     = r_state;
        n_cur_row   = r_cur_row;
        n_cur_col   = r_cur_col;
        n_base      = r_base;
        n_view      = r_view;
        n_rd_hit    = r_rd_hit;
        n_rd_live   = r_rd_live;
        n_out_valid = r_out_valid && !i_ready;
        n_out_char  = r_out_char;
        n_out_live  = r_out_live;
        n_out_view  = r_out_view;
        n_out_crow  = r_out_crow;
        n_out_ccol  = r_out_ccol;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        fill_clr    = 1'b0;
        fill_set    = 1'b0;
        view_sum    = 0;

        unique case (r_state)
            tts_pkg::BK_EXEC: begin
                if (pop) begin
                    unique case (i_cmd.op)
                        tts_pkg::OP_CHAR: begin
                            n_base   = scroll ? base_inc : r_base;
                            fill_clr = scroll;
                            fill_set = 1'b1;
                            mem_we   = 1'b1;
                            if (32'(col_eff) == tts_pkg::COLUMNS - 1) begin
                                n_cur_row = tts_pkg::CROW_W'(row_eff) + 1'b1;
                                n_cur_col = '0;
                            end else begin
                                n_cur_row = tts_pkg::CROW_W'(row_eff);
                                n_cur_col = col_eff + 1'b1;
                            end
                        end
                        tts_pkg::OP_NEWLINE: begin
                            n_base    = scroll ? base_inc : r_base;
                            fill_clr  = scroll;
                            n_cur_row = tts_pkg::CROW_W'(row_eff) + 1'b1;
                            n_cur_col = '0;
                        end
                        tts_pkg::OP_PAIR_SKIP: begin
                            // the scroll still happens, the break itself is dropped
                            n_base    = scroll ? base_inc : r_base;
                            fill_clr  = scroll;
                            n_cur_row = tts_pkg::CROW_W'(row_eff);
                            n_cur_col = col_eff;
                        end
                        tts_pkg::OP_PAGE_UP: begin
                            if (32'(r_view) < tts_pkg::SCREEN_ROWS) begin
                                n_view = '0;
                            end else begin
                                n_view = tts_pkg::VIEW_W'(32'(r_view) - tts_pkg::SCREEN_ROWS);
                            end
                        end
                        tts_pkg::OP_PAGE_DOWN: begin
                            view_sum = 32'(r_view) + tts_pkg::SCREEN_ROWS;
                            if (view_sum > tts_pkg::LAST_VIEW) begin
                                n_view = tts_pkg::VIEW_W'(tts_pkg::LAST_VIEW);
                            end else begin
                                n_view = tts_pkg::VIEW_W'(view_sum);
                            end
                        end
                        tts_pkg::OP_READ: begin
                            mem_re    = 1'b1;
                            n_rd_hit  = tts_pkg::FILL_W'(rd_col) < r_fill[rd_prow];
                            n_rd_live = (32'(st_row) >= tts_pkg::LAST_VIEW);
                            n_state   = tts_pkg::BK_READ;
                        end
                        default: begin
                        end
                    endcase

                    // Everything but an in-screen read reports at once
                    if (i_cmd.op != tts_pkg::OP_READ) begin
                        n_out_valid = 1'b1;
                        n_out_char  = tts_pkg::CHAR_NONE;
                        n_out_live  = 1'b0;
                        n_out_view  = n_view;
                        n_out_crow  = n_cur_row;
                        n_out_ccol  = n_cur_col;
                    end
                end
            end
            tts_pkg::BK_READ: begin
                // result slot is free here: it was free or draining at the pop
                n_out_valid = 1'b1;
                n_out_char  = r_rd_hit ? r_rd_data : tts_pkg::CHAR_SPACE;
                n_out_live  = r_rd_live;
                n_out_view  = r_view;
                n_out_crow  = r_cur_row;
                n_out_ccol  = r_cur_col;
                n_state     = tts_pkg::BK_EXEC;
            end
            default: n_state = tts_pkg::BK_EXEC;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tts_pkg::BK_EXEC;
            r_cur_row   <= tts_pkg::CROW_W'(tts_pkg::LAST_VIEW);
            r_cur_col   <= '0;
            r_base      <= '0;
            r_view      <= tts_pkg::VIEW_W'(tts_pkg::LAST_VIEW);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur_row   <= n_cur_row;
            r_cur_col   <= n_cur_col;
            r_base      <= n_base;
            r_view      <= n_view;
            r_out_valid <= n_out_valid;
        end
    end

    // Row fill lengths: columns past the fill read as space
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < tts_pkg::TOTAL_ROWS; i++) begin
                r_fill[i] <= '0;
            end
        end else begin
            // a write after a scroll lands on the row being blanked
            if (fill_set) begin
                r_fill[wr_prow] <= fill_val;
            end else if (fill_clr) begin
                r_fill[r_base] <= '0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rd_hit   <= n_rd_hit;
        r_rd_live  <= n_rd_live;
        r_out_char <= n_out_char;
        r_out_live <= n_out_live;
        r_out_view <= n_out_view;
        r_out_crow <= n_out_crow;
        r_out_ccol <= n_out_ccol;
    end

    // Text store write port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= i_cmd.code;
        end
    end

    // Text store read port
    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    assign o_valid         = r_out_valid;
    assign o_cell_char     = r_out_char;
    assign o_cell_is_live  = r_out_live;
    assign o_view_top_row  = tts_pkg::VIEW_OUT_W'(r_out_view);
    assign o_cursor_row    = tts_pkg::CROW_OUT_W'(r_out_crow);
    assign o_cursor_column = tts_pkg::CCOL_OUT_W'(r_out_ccol);

endmodule

`default_nettype wire

// ===== rtl/text_terminal_scrollback_buffer.sv =====
// Top level of the text terminal scrollback buffer.
// Instantiates tts_front, tts_queue and tts_back; uses tts_pkg.
//
//  Channel  Direction  Handshake                 Payload
//  in       input      i_in_valid / o_in_ready   action, char_code, screen_row, screen_column
//  out      output     o_out_valid / i_out_ready cell_char, cell_is_live, view_top_row,
//                                                cursor_row, cursor_column
//
// Writes, newlines, page moves and off-screen reads report straight from the execute state;
// an in-screen read passes through the BK_READ state, as the text store has a registered read port.
// A two-entry command queue lets the front end keep accepting while the back end stalls, until it is full.
// Reset is synchronous; the store needs no clearing pass, as per-row fill lengths
// (cleared at reset) make unwritten cells read as space.
// One result per item, in order; the result register holds until it is taken.
`default_nettype none

module text_terminal_scrollback_buffer (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_in_valid,
    output logic                            o_in_ready,
    input  wire  [tts_pkg::ACTION_W-1:0]    i_action,
    input  wire  [tts_pkg::CHAR_W-1:0]      i_char_code,
    input  wire  [tts_pkg::SROW_W-1:0]      i_screen_row,
    input  wire  [tts_pkg::SCOL_W-1:0]      i_screen_column,
    output logic                            o_out_valid,
    input  wire                             i_out_ready,
    output logic [tts_pkg::CHAR_W-1:0]      o_cell_char,
    output logic                            o_cell_is_live,
    output logic [tts_pkg::VIEW_OUT_W-1:0]  o_view_top_row,
    output logic [tts_pkg::CROW_OUT_W-1:0]  o_cursor_row,
    output logic [tts_pkg::CCOL_OUT_W-1:0]  o_cursor_column
);

    logic          front_valid;
    logic          front_ready;
    tts_pkg::t_cmd front_cmd;
    logic          back_valid;
    logic          back_ready;
    tts_pkg::t_cmd back_cmd;

    tts_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_in_valid),
        .o_ready         (o_in_ready),
        .i_action        (i_action),
        .i_char_code     (i_char_code),
        .i_screen_row    (i_screen_row),
        .i_screen_column (i_screen_column),
        .o_cmd_valid     (front_valid),
        .o_cmd           (front_cmd),
        .i_cmd_ready     (front_ready)
    );

    tts_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_cmd   (front_cmd),
        .o_pop_valid  (back_valid),
        .i_pop_ready  (back_ready),
        .o_pop_cmd    (back_cmd)
    );

    tts_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (back_valid),
        .o_cmd_ready     (back_ready),
        .i_cmd           (back_cmd),
        .o_valid         (o_out_valid),
        .i_ready         (i_out_ready),
        .o_cell_char     (o_cell_char),
        .o_cell_is_live  (o_cell_is_live),
        .o_view_top_row  (o_view_top_row),
        .o_cursor_row    (o_cursor_row),
        .o_cursor_column (o_cursor_column)
    );

    // Cursor never passes the scroll-pending row
    a_cursor_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_cursor_row) <= tts_pkg::TOTAL_ROWS))
        else $error("cursor row beyond store");

    // Scroll-pending cursor sits at column zero
    a_pending_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (32'(o_cursor_row) == tts_pkg::TOTAL_ROWS))
            |-> (o_cursor_column == '0))
        else $error("scroll pending with nonzero column");

    // View stays clamped to the store
    a_view_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_view_top_row) <= tts_pkg::LAST_VIEW))
        else $error("view beyond last screen");

    // A live cell needs the view to reach into the last screen
    a_live_view: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_cell_is_live)
            |-> (32'(o_view_top_row) + tts_pkg::SCREEN_ROWS > tts_pkg::LAST_VIEW))
        else $error("live cell outside reachable view");

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Testbench for the text terminal scrollback buffer: a directed table, then random traffic.
// Results are checked against typed expectations or a behavioral terminal copy here.
// Depends on rtl/tts_pkg.sv and rtl/text_terminal_scrollback_buffer.sv.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tts_pkg::*;

    localparam int RANDOM_ITEMS = 400;
    localparam int CALM_TAIL    = 60;
    localparam int DIRECTED_N   = 24;

    typedef struct packed {
        logic [CHAR_W-1:0]     ch;
        logic                  live;
        logic [VIEW_OUT_W-1:0] view;
        logic [CROW_OUT_W-1:0] crow;
        logic [CCOL_OUT_W-1:0] ccol;
    } t_cell_result;

    // One input transfer, with an optional hand-written expectation
    typedef struct packed {
        t_action           act;
        logic [CHAR_W-1:0] code;
        logic [SROW_W-1:0] row;
        logic [SCOL_W-1:0] col;
        logic              typed;
        t_cell_result      want;
    } t_stim;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_in_valid;
    logic i_out_ready;
    t_stim in_flight;
    bit   idle_on;
    logic o_in_ready;
    logic o_out_valid;
    logic [CHAR_W-1:0]     o_cell_char;
    logic                  o_cell_is_live;
    logic [VIEW_OUT_W-1:0] o_view_top_row;
    logic [CROW_OUT_W-1:0] o_cursor_row;
    logic [CCOL_OUT_W-1:0] o_cursor_column;

    wire [ACTION_W-1:0] i_action        = in_flight.act;
    wire [CHAR_W-1:0]   i_char_code     = in_flight.code;
    wire [SROW_W-1:0]   i_screen_row    = in_flight.row;
    wire [SCOL_W-1:0]   i_screen_column = in_flight.col;

    // Terminal copy used for prediction
    logic [CHAR_W-1:0] term_text [0:TOTAL_CHARS-1];
    int unsigned       term_cursor;
    int unsigned       term_view;
    logic [CHAR_W-1:0] term_prev_char;

    t_cell_result due_results[$];
    t_stim        directed_rows [DIRECTED_N];
    int           mismatch_count;
    int           transfer_count;
    int           scroll_count;
    int           pair_count;
    int           history_reads;
    int           live_reads;
    int           page_moves;

    text_terminal_scrollback_buffer DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_char_code    (i_char_code),
        .i_screen_row   (i_screen_row),
        .i_screen_column(i_screen_column),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_cell_char    (o_cell_char),
        .o_cell_is_live (o_cell_is_live),
        .o_view_top_row (o_view_top_row),
        .o_cursor_row   (o_cursor_row),
        .o_cursor_column(o_cursor_column)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Apply one transfer to the terminal copy and return what the block should report
    function automatic t_cell_result advance_terminal(input t_stim s);
        t_cell_result r;
        int unsigned  store_row;
        int unsigned  at;
        r = '0;
        case (s.act)
            ACT_WRITE: begin
                // cursor past the end: scroll up, blank the last row
                if (term_cursor >= TOTAL_CHARS) begin
                    for (int i = 0; i < TOTAL_CHARS - COLUMNS; i++)
                        term_text[i] = term_text[i + COLUMNS];
                    for (int i = TOTAL_CHARS - COLUMNS; i < TOTAL_CHARS; i++)
                        term_text[i] = CHAR_SPACE;
                    term_cursor = TOTAL_CHARS - COLUMNS;
                    scroll_count++;
                end
                if (s.code == CHAR_CR || s.code == CHAR_LF) begin
                    // second half of CR-LF or LF-CR is dropped
                    if ((s.code == CHAR_CR && term_prev_char == CHAR_LF) ||
                        (s.code == CHAR_LF && term_prev_char == CHAR_CR))
                        pair_count++;
                    else
                        term_cursor = (term_cursor / COLUMNS + 1) * COLUMNS;
                end else begin
                    term_text[term_cursor] = s.code;
                    term_cursor++;
                end
                term_prev_char = s.code;
            end
            ACT_PAGE_UP: begin
                term_view = (term_view < SCREEN_ROWS) ? 0 : term_view - SCREEN_ROWS;
                page_moves++;
            end
            ACT_PAGE_DOWN: begin
                term_view = term_view + SCREEN_ROWS;
                if (term_view > LAST_VIEW)
                    term_view = LAST_VIEW;
                page_moves++;
            end
            default: begin
                if (s.row < SCREEN_ROWS && s.col < COLUMNS) begin
                    store_row = term_view + s.row;
                    at        = store_row * COLUMNS + s.col;
                    if (at < TOTAL_CHARS) begin
                        r.ch   = term_text[at];
                        r.live = (store_row >= LAST_VIEW);
                        if (r.live)
                            live_reads++;
                        else
                            history_reads++;
                    end
                end
            end
        endcase
        r.view = VIEW_OUT_W'(term_view);
        r.crow = CROW_OUT_W'(term_cursor / COLUMNS);
        r.ccol = CCOL_OUT_W'(term_cursor % COLUMNS);
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Input transfers feed the terminal copy; output transfers are compared in order
    always @(posedge i_clk) begin : transfer_check
        t_cell_result predicted;
        t_cell_result want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                predicted = advance_terminal(in_flight);
                due_results.push_back(in_flight.typed ? in_flight.want : predicted);
                transfer_count++;
            end
            if (o_out_valid && i_out_ready) begin
                if (due_results.size() == 0) begin
                    $error("result transfer with nothing expected");
                    mismatch_count++;
                end else begin
                    want = due_results.pop_front();
                    check_field("cell_char", want.ch, o_cell_char);
                    check_field("cell_is_live", want.live, o_cell_is_live);
                    check_field("view_top_row", want.view, o_view_top_row);
                    check_field("cursor_row", want.crow, o_cursor_row);
                    check_field("cursor_column", want.ccol, o_cursor_column);
                end
            end
        end
    end

    // Result side: random stall bursts while idling is on
    initial begin : out_stall
        int stall_left;
        stall_left  = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (idle_on && stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 9);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic feed_item(input t_stim s);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        in_flight  <= s;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin : run_traffic
        t_stim s;
        int    sent;
        int    run_len;
        int    pick;

        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        in_flight  = '0;
        idle_on    = 1'b1;
        sent       = 0;
        mismatch_count = 0;
        transfer_count = 0;
        scroll_count   = 0;
        pair_count     = 0;
        history_reads  = 0;
        live_reads     = 0;
        page_moves     = 0;

        for (int i = 0; i < TOTAL_CHARS; i++)
            term_text[i] = CHAR_SPACE;
        term_cursor    = LAST_VIEW * COLUMNS;
        term_view      = LAST_VIEW;
        term_prev_char = CHAR_NONE;

        // act, code, row, col, typed, {char, live, view, cursor row, cursor col}
        directed_rows = '{
            '{ACT_READ,      8'h00,   4'd0,  6'd0,  1'b1, '{8'h20, 1'b1, 6'd48, 7'd48, 6'd0}},
            '{ACT_READ,      8'h00,   4'd15, 6'd63, 1'b1, '{8'h20, 1'b1, 6'd48, 7'd48, 6'd0}},
            '{ACT_PAGE_DOWN, 8'h00,   4'd0,  6'd0,  1'b1, '{8'h00, 1'b0, 6'd48, 7'd48, 6'd0}},
            '{ACT_WRITE,     8'h41,   4'd0,  6'd0,  1'b1, '{8'h00, 1'b0, 6'd48, 7'd48, 6'd1}},
            '{ACT_WRITE,     8'hFF,   4'd15, 6'd63, 1'b1, '{8'h00, 1'b0, 6'd48, 7'd48, 6'd2}},
            '{ACT_WRITE,     8'h00,   4'd0,  6'd0,  1'b1, '{8'h00, 1'b0, 6'd48, 7'd48, 6'd3}},
            '{ACT_READ,      8'hFF,   4'd0,  6'd0,  1'b1, '{8'h41, 1'b1, 6'd48, 7'd48, 6'd3}},
            '{ACT_READ,      8'h00,   4'd0,  6'd1,  1'b1, '{8'hFF, 1'b1, 6'd48, 7'd48, 6'd3}},
            '{ACT_WRITE,     CHAR_CR, 4'd0,  6'd0,  1'b1, '{8'h00, 1'b0, 6'd48, 7'd49, 6'd0}},
            '{ACT_WRITE,     CHAR_LF, 4'd0,  6'd0,  1'b1, '{8'h00, 1'b0, 6'd48, 7'd49, 6'd0}},
            '{ACT_WRITE,     CHAR_LF, 4'd0,  6'd0,  1'b1, '{8'h00, 1'b0, 6'd48, 7'd50, 6'd0}},
            '{ACT_WRITE,     CHAR_CR, 4'd0,  6'd0,  1'b1, '{8'h00, 1'b0, 6'd48, 7'd50, 6'd0}},
            '{ACT_WRITE,     CHAR_CR, 4'd0,  6'd0,  1'b0, '0},
            '{ACT_PAGE_UP,   8'h00,   4'd0,  6'd0,  1'b1, '{8'h00, 1'b0, 6'd32, 7'd51, 6'd0}},
            '{ACT_PAGE_UP,   8'h00,   4'd0,  6'd0,  1'b0, '0},
            '{ACT_PAGE_UP,   8'h00,   4'd0,  6'd0,  1'b0, '0},
            '{ACT_PAGE_UP,   8'h00,   4'd0,  6'd0,  1'b1, '{8'h00, 1'b0, 6'd0,  7'd51, 6'd0}},
            '{ACT_READ,      8'h00,   4'd15, 6'd63, 1'b1, '{8'h20, 1'b0, 6'd0,  7'd51, 6'd0}},
            '{ACT_PAGE_DOWN, 8'h00,   4'd0,  6'd0,  1'b0, '0},
            '{ACT_PAGE_DOWN, 8'h00,   4'd0,  6'd0,  1'b0, '0},
            '{ACT_PAGE_DOWN, 8'h00,   4'd0,  6'd0,  1'b0, '0},
            '{ACT_READ,      8'h00,   4'd1,  6'd0,  1'b0, '0},
            '{ACT_WRITE,     8'h7E,   4'd0,  6'd0,  1'b0, '0},
            '{ACT_READ,      8'h00,   4'd0,  6'd2,  1'b1, '{8'h00, 1'b1, 6'd48, 7'd51, 6'd1}}
        };

        // hold synchronous reset, then release it on a falling edge
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i])
            feed_item(directed_rows[i]);

        // Random part: single items mixed with long text lines ending in a newline
        while (sent < RANDOM_ITEMS) begin
            idle_on = (sent < RANDOM_ITEMS - CALM_TAIL) && ((sent / 50) % 3 != 2);
            if ($urandom_range(0, 15) == 0) begin
                run_len = $urandom_range(20, 90);
                for (int k = 0; k < run_len; k++) begin
                    s      = '0;
                    s.act  = ACT_WRITE;
                    s.code = CHAR_W'($urandom_range(0, 255));
                    if (s.code == CHAR_CR || s.code == CHAR_LF)
                        s.code = CHAR_SPACE;
                    s.row  = SROW_W'($urandom_range(0, 15));
                    s.col  = SCOL_W'($urandom_range(0, 63));
                    feed_item(s);
                end
                s      = '0;
                s.act  = ACT_WRITE;
                s.code = $urandom_range(0, 1) ? CHAR_CR : CHAR_LF;
                feed_item(s);
                sent += run_len + 1;
            end else begin
                pick   = $urandom_range(0, 99);
                s      = '0;
                s.code = CHAR_W'($urandom_range(0, 255));
                s.row  = SROW_W'($urandom_range(0, 15));
                s.col  = SCOL_W'($urandom_range(0, 63));
                if (pick < 50) begin
                    s.act = ACT_WRITE;
                    if (pick < 12)
                        s.code = CHAR_CR;
                    else if (pick < 24)
                        s.code = CHAR_LF;
                end else if (pick < 58) begin
                    s.act = ACT_PAGE_UP;
                end else if (pick < 66) begin
                    s.act = ACT_PAGE_DOWN;
                end else begin
                    s.act = ACT_READ;
                end
                feed_item(s);
                sent++;
            end
        end
        i_in_valid <= 1'b0;

        // drain, then keep watching for anything unexpected
        while (due_results.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Checked %0d transfers: %0d scrolls, %0d merged newline pairs, %0d page moves",
                 transfer_count, scroll_count, pair_count, page_moves);
        $display("Screen reads: %0d on the live screen, %0d in history",
                 live_reads, history_reads);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Hang guard
    initial begin : watchdog
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

// ===== text_terminal_scrollback_buffer.f =====
rtl/tts_pkg.sv
rtl/tts_front.sv
rtl/tts_queue.sv
rtl/tts_back.sv
rtl/text_terminal_scrollback_buffer.sv
verif/tb_top.sv
